### rtl/lrutc_pkg.sv
// ----------------------------------------------------------------------------
// lrutc_pkg
// Types and constants shared by the LRU tag cache timestamp unit.
// ----------------------------------------------------------------------------
package lrutc_pkg;

  localparam int KEY_W   = 16;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 3;

  localparam logic [STAMP_W-1:0] STAMP_BOUND = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACEHOLDER = 3'd0,
    ST_HIT         = 3'd1,
    ST_FILLED      = 3'd2,
    ST_LOAD_FAILED = 3'd3,
    ST_NO_LOOKUP   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

### rtl/lrutc_ram.sv
// ----------------------------------------------------------------------------
// lrutc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrutc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lrutc_scan.sv
// ----------------------------------------------------------------------------
// lrutc_scan
// Compare unit stepped once per slot: tracks the first key hit, the first
// free slot and the oldest stamp seen before it.
// ----------------------------------------------------------------------------
module lrutc_scan
  import lrutc_pkg::*;
#(
  parameter int IW = 6
) (
  input  logic               clk,
  input  logic               clear,
  input  logic               en,
  input  logic [IW-1:0]      idx,
  input  logic               ent_valid,
  input  logic [KEY_W-1:0]   ent_key,
  input  logic [STAMP_W-1:0] ent_stamp,
  input  logic [KEY_W-1:0]   match_key,
  output logic               hit,
  output logic [IW-1:0]      hit_idx,
  output logic [IW-1:0]      victim_idx,
  output logic               victim_valid,
  output logic [KEY_W-1:0]   victim_key
);

  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [IW-1:0]      vic_r, vic_nxt;
  logic [KEY_W-1:0]   vkey_r, vkey_nxt;
  logic [STAMP_W-1:0] oldest_r, oldest_nxt;

  always_comb begin
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_nxt    = free_r;
    vic_nxt     = vic_r;
    vkey_nxt    = vkey_r;
    oldest_nxt  = oldest_r;
    if (clear) begin
      hit_nxt    = 1'b0;
      free_nxt   = 1'b0;
      vic_nxt    = '0;
      vkey_nxt   = '0;
      oldest_nxt = STAMP_BOUND;
    end else if (en) begin
      if (!hit_r && ent_valid && (ent_key == match_key)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = idx;
      end
      if (!free_r) begin
        if (!ent_valid) begin
          free_nxt = 1'b1;
          vic_nxt  = idx;
        end else if ((ent_stamp < oldest_r) || (idx == '0)) begin
          // slot 0 is the default victim, so always take its key
          oldest_nxt = ent_stamp;
          vic_nxt    = idx;
          vkey_nxt   = ent_key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    free_r    <= free_nxt;
    vic_r     <= vic_nxt;
    vkey_r    <= vkey_nxt;
    oldest_r  <= oldest_nxt;
  end

  assign hit          = hit_r;
  assign hit_idx      = hit_idx_r;
  assign victim_idx   = vic_r;
  assign victim_valid = !free_r;
  assign victim_key   = vkey_r;

endmodule

### rtl/lru_tag_cache_timestamp_unit.sv
// ----------------------------------------------------------------------------
// lru_tag_cache_timestamp_unit
// Fully associative tag store with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// A tick, a flush, op code 3 or an ineligible touch is taken straight from idle
// and its result strobes out_valid in the next cycle, with busy staying low. An
// eligible touch walks all SLOTS entries through the key/stamp RAM read port,
// one slot per cycle, so busy stays high through the scan, drain and done states
// and the result strobes in the cycle that busy falls. There is no clearing pass
// after reset. Results are shown for one cycle only; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module lru_tag_cache_timestamp_unit
  import lrutc_pkg::*;
#(
  parameter int SLOTS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [KEY_W-1:0]   in_key,
  input  logic               in_eligible,
  input  logic               in_load_ok,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_evicted_valid,
  output logic [KEY_W-1:0]   out_evicted_key
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = KEY_W + STAMP_W;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               load_ok_r, load_ok_nxt;
  logic [STAMP_W-1:0] frame_r, frame_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic               rd_pend_r;
  logic [IW-1:0]      rd_idx_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]   out_ekey_r, out_ekey_nxt;

  logic               accept;
  logic               ram_we;
  logic [DW-1:0]      ram_rdata;
  logic               sc_hit, sc_vvalid;
  logic [IW-1:0]      sc_hit_idx, sc_vidx, sel_idx;
  logic [KEY_W-1:0]   sc_vkey;
  logic [IW+SLOT_W-1:0] slot_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign sel_idx  = sc_hit ? sc_hit_idx : sc_vidx;
  assign slot_ext = (IW + SLOT_W)'(sel_idx);
  assign ram_we   = (state_r == S_DONE) && (sc_hit || load_ok_r);

  lrutc_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_idx),
    .wdata ({key_r, frame_r}),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  lrutc_scan #(
    .IW (IW)
  ) u_scan (
    .clk          (clk),
    .clear        (accept),
    .en           (rd_pend_r),
    .idx          (rd_idx_r),
    .ent_valid    (valid_r[rd_idx_r]),
    .ent_key      (ram_rdata[DW-1:STAMP_W]),
    .ent_stamp    (ram_rdata[STAMP_W-1:0]),
    .match_key    (key_r),
    .hit          (sc_hit),
    .hit_idx      (sc_hit_idx),
    .victim_idx   (sc_vidx),
    .victim_valid (sc_vvalid),
    .victim_key   (sc_vkey)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    load_ok_nxt    = load_ok_r;
    frame_nxt      = frame_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_ekey_nxt   = out_ekey_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_slot_nxt = '0;
          out_ev_nxt   = 1'b0;
          out_ekey_nxt = '0;
          case (op_t'(in_op))
            OP_TOUCH: begin
              if (in_eligible) begin
                key_nxt     = in_key;
                load_ok_nxt = in_load_ok;
                cnt_nxt     = '0;
                state_nxt   = S_SCAN;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_PLACEHOLDER;
              end
            end
            OP_TICK: begin
              frame_nxt      = frame_r + 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NO_LOOKUP;
            end
            OP_FLUSH: begin
              valid_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NO_LOOKUP;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NO_LOOKUP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one slot read per cycle
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = slot_ext[SLOT_W-1:0];
        if (sc_hit) begin
          out_status_nxt = ST_HIT;
          out_ev_nxt     = 1'b0;
          out_ekey_nxt   = '0;
        end else begin
          out_ev_nxt   = sc_vvalid;
          out_ekey_nxt = sc_vvalid ? sc_vkey : '0;
          if (load_ok_r) begin
            out_status_nxt     = ST_FILLED;
            valid_nxt[sel_idx] = 1'b1;
          end else begin
            out_status_nxt     = ST_LOAD_FAILED;
            valid_nxt[sel_idx] = 1'b0;
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      frame_r     <= '0;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      frame_r     <= frame_nxt;
      valid_r     <= valid_nxt;
      rd_pend_r   <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    load_ok_r    <= load_ok_nxt;
    rd_idx_r     <= cnt_r[IW-1:0];
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_ekey_r   <= out_ekey_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_key   = out_ekey_r;

endmodule
